FILE: hdl/ntsm_pkg.sv
// Shared types, constants and helper functions for the nearest template
// sequence match core. No dependencies.
`default_nettype none

package ntsm_pkg;

  // Sequence geometry: bases per sequence, bits per base, field width.
  localparam int SeqLen      = 20;
  localparam int BaseW       = 2;
  localparam int DataW       = 40;
  localparam int FieldBases  = DataW / BaseW;
  localparam int SkipCount   = (SeqLen + 2) / 3;
  localparam int CountedPos  = SeqLen - SkipCount;
  localparam int CountW      = $clog2(CountedPos + 1);
  localparam int MatchW      = 4;
  localparam int FitW        = 16;
  localparam int FitOne      = 32768;

  // Template set, one per ordered substance pair, in i-major order.
  localparam int NumTemplates = 6;
  localparam int TmplIdxW     = $clog2(NumTemplates);
  localparam logic [1:0] PairIn  [NumTemplates] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] PairOut [NumTemplates] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

  // Configuration port geometry: 64-bit registers at 8-byte strides.
  localparam int ApbDataW  = 64;
  localparam int ApbAddrW  = 6;
  localparam int RegIdxW   = 3;
  localparam int SubstW    = 2;

  typedef enum logic [RegIdxW-1:0] {
    RegSubstCount = 3'd0,
    RegTmpl01     = 3'd1,
    RegTmpl02     = 3'd2,
    RegTmpl10     = 3'd3,
    RegTmpl12     = 3'd4,
    RegTmpl20     = 3'd5,
    RegTmpl21     = 3'd6
  } reg_idx_e;

  // Result word, first field in the highest bits.
  typedef struct packed {
    logic [FitW-1:0]   fit;
    logic [MatchW-1:0] match_count;
    logic [1:0]        out_substance;
    logic [1:0]        in_substance;
  } result_t;

  // Count matching bases at every position whose index is not a multiple of
  // three. Bases above the data field read as A on both sides and match.
  function automatic logic [CountW-1:0] count_matches(input logic [DataW-1:0] a,
                                                      input logic [DataW-1:0] b);
    logic [CountW-1:0] m;
    m = '0;
    for (int k = 0; k < SeqLen; k++) begin
      if (k % 3 != 0) begin
        if (k >= FieldBases) begin
          m = m + CountW'(1);
        end else if (a[BaseW*k +: BaseW] == b[BaseW*k +: BaseW]) begin
          m = m + CountW'(1);
        end
      end
    end
    return m;
  endfunction

  // Fit in unsigned Q1.15, rounded down, looked up from a constant table
  // with one entry per possible match count.
  function automatic logic [FitW-1:0] fit_of(input logic [CountW-1:0] m);
    logic [FitW-1:0] f;
    f = '0;
    for (int i = 0; i <= CountedPos; i++) begin
      if (m == CountW'(i)) begin
        f = FitW'((i * FitOne) / CountedPos);
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/nearest_template_sequence_match_core.sv
// Top level of the nearest template sequence match core: configuration
// registers, one compare stage and the result register. Depends on ntsm_pkg.
`default_nettype none

// Each accepted 40-bit sequence word is compared with the enabled templates
// (0-1 and 1-0, or all six pairs when substance_count is 3), skipping base
// positions that are multiples of three. The result word carries the pair of
// the best template (earliest in i-major order on ties), its match count and
// the fit in Q1.15. One word is accepted every clock cycle while the result
// side does not stall; each accepted sequence is held in the input register,
// where all template comparisons run in parallel, and its result is then
// held in the result register until taken. Backpressure from the result
// side stalls both stages.
module nearest_template_sequence_match_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Sequence input stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [ntsm_pkg::DataW-1:0]   s_axis_tdata,   // [39:0] sequence_req
  // Result output stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [1:0] in_substance, [3:2] out_substance, [7:4] match_count, [23:8] fit
  output logic [23:0]                       m_axis_tdata,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ntsm_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [ntsm_pkg::ApbDataW-1:0] pwdata,
  output logic [ntsm_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  import ntsm_pkg::*;

  logic [SubstW-1:0] subst_count_q;
  logic [DataW-1:0]  tmpl_q [NumTemplates];
  logic              cfg_wr;
  logic [RegIdxW-1:0] reg_idx;

  logic              s1_valid_q;
  logic [DataW-1:0]  s1_seq_q;
  logic              out_valid_q;
  result_t           out_q;
  result_t           result_d;
  logic              advance;

  logic [CountW-1:0] match [NumTemplates];
  logic [CountW-1:0] best_m;
  logic [TmplIdxW-1:0] best_t;
  logic              three;

  // Configuration write and read decode.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[ApbAddrW-1 -: RegIdxW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subst_count_q <= SubstW'(2);
      for (int t = 0; t < NumTemplates; t++) begin
        tmpl_q[t] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        RegSubstCount: subst_count_q <= pwdata[SubstW-1:0];
        RegTmpl01:     tmpl_q[0] <= pwdata[DataW-1:0];
        RegTmpl02:     tmpl_q[1] <= pwdata[DataW-1:0];
        RegTmpl10:     tmpl_q[2] <= pwdata[DataW-1:0];
        RegTmpl12:     tmpl_q[3] <= pwdata[DataW-1:0];
        RegTmpl20:     tmpl_q[4] <= pwdata[DataW-1:0];
        RegTmpl21:     tmpl_q[5] <= pwdata[DataW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegSubstCount: prdata = ApbDataW'(subst_count_q);
      RegTmpl01:     prdata = ApbDataW'(tmpl_q[0]);
      RegTmpl02:     prdata = ApbDataW'(tmpl_q[1]);
      RegTmpl10:     prdata = ApbDataW'(tmpl_q[2]);
      RegTmpl12:     prdata = ApbDataW'(tmpl_q[3]);
      RegTmpl20:     prdata = ApbDataW'(tmpl_q[4]);
      RegTmpl21:     prdata = ApbDataW'(tmpl_q[5]);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage moves when the one after it can take it.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_seq_q <= s_axis_tdata;
    end
  end

  // Compare against all templates in parallel and keep the first best one.
  assign three = (subst_count_q == SubstW'(3));

  always_comb begin
    for (int t = 0; t < NumTemplates; t++) begin
      match[t] = count_matches(s1_seq_q, tmpl_q[t]);
    end
    best_t = '0;
    best_m = match[0];
    for (int t = 1; t < NumTemplates; t++) begin
      if ((three || (PairIn[t] != 2'd2 && PairOut[t] != 2'd2)) && match[t] > best_m) begin
        best_t = TmplIdxW'(t);
        best_m = match[t];
      end
    end
    result_d.in_substance  = PairIn[best_t];
    result_d.out_substance = PairOut[best_t];
    result_d.match_count   = (best_m > CountW'(15)) ? MatchW'(15) : MatchW'(best_m);
    result_d.fit           = fit_of(best_m);
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // The input side takes a word whenever the compare stage is empty.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready)
    else $error("input stall with an empty compare stage");

  // A result never reports more matches than counted positions.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(out_q.match_count) <= CountedPos))
    else $error("match count above counted positions");

  // A full match reports a fit of one.
  a_full_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && 32'(out_q.match_count) == CountedPos) |-> (out_q.fit == FitW'(FitOne)))
    else $error("full match without a fit of one");

  // The reported pair always names two different substances.
  a_pair_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.in_substance != out_q.out_substance))
    else $error("result pair names the same substance twice");

endmodule

`default_nettype wire
